// File: rtl/core/tirv_pkg.sv
// Package for the tensor index ravel/unravel core: stage record, codes and
// shape constants. Depends on nothing; imported by tensor_index_ravel_unravel_core and its testbench.
`timescale 1ns / 1ps
package tirv_pkg;

   localparam int NUM_FIELDS = 4;          // dimension fields on the ports
   localparam int MAX_DIMS   = 4;          // largest dimension count honored
   localparam int COORD_W    = 16;
   localparam int FLAT_W     = 31;
   localparam int STRIDE_W   = 32;         // saturated stride / volume
   localparam int PROD_W     = COORD_W + STRIDE_W;
   localparam int SHIFT_W    = FLAT_W + COORD_W;

   localparam logic [PROD_W-1:0]   VOL_LIMIT = PROD_W'(32'h7FFF_FFFF);
   localparam logic [STRIDE_W-1:0] VOL_SAT   = 32'h8000_0000;

   // Divider layout: one quotient bit per step, two steps per stage.
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = (NUM_FIELDS * COORD_W) / DIV_STEPS;
   localparam int DIV_FIRST  = 4;
   localparam int NUM_STAGES = DIV_FIRST + DIV_STAGES + 1;

   localparam logic OP_RAVEL   = 1'b0;
   localparam logic OP_UNRAVEL = 1'b1;

   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_OVF   = 2'd1;
   localparam logic [1:0] STS_RANGE = 2'd2;

   localparam logic [2:0] REG_NUM_DIMS = 3'd0;
   localparam logic [2:0] REG_DIM_0    = 3'd1;
   localparam logic [2:0] REG_DIM_1    = 3'd2;
   localparam logic [2:0] REG_DIM_2    = 3'd3;
   localparam logic [2:0] REG_DIM_3    = 3'd4;

   typedef struct packed {
      logic                                  op;
      logic [NUM_FIELDS-1:0][COORD_W-1:0]    crd;
      logic [NUM_FIELDS-1:0][COORD_W-1:0]    ext;
      logic [NUM_FIELDS-1:0][COORD_W-1:0]    qt;
      logic [FLAT_W-1:0]                     rem;
      logic [STRIDE_W-1:0]                   pa;
      logic [STRIDE_W-1:0]                   pb;
      logic [NUM_FIELDS-1:0][STRIDE_W-1:0]   strd;
      logic [NUM_FIELDS-1:0][FLAT_W-1:0]     prod;
      logic [FLAT_W-1:0]                     flat_sum;
      logic                                  rng_bad;
      logic                                  ovf;
      logic [1:0]                            sts;
   } tirv_stage_type;

   // Clamp a product to just above the volume limit.
   function automatic logic [STRIDE_W-1:0] tirv_sat(input logic [PROD_W-1:0] x);
      return (x > VOL_LIMIT) ? VOL_SAT : x[STRIDE_W-1:0];
   endfunction

endpackage

// File: rtl/core/tensor_index_ravel_unravel_core.sv
// Row-major tensor coordinate <-> flat index converter, top level.
// Depends on tirv_pkg for the stage record, codes and constants.
// A word accepted at one edge passes 37 register stages to the response port;
// a new word can enter every cycle while rsp_ready does not stall it. The depth
// is set by the 32-stage restoring divider, two quotient bits per stage.
// Synchronous active-high reset empties the pipeline and sets one dimension.
`timescale 1ns / 1ps
module tensor_index_ravel_unravel_core (
   input  logic        clock,
   input  logic        reset,
   // Configuration write port.
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   // Request channel.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [15:0] req_coord_in_0,
   input  logic [15:0] req_coord_in_1,
   input  logic [15:0] req_coord_in_2,
   input  logic [15:0] req_coord_in_3,
   input  logic [30:0] req_flat_index_in,
   // Response channel.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [30:0] rsp_flat_index_out,
   output logic [15:0] rsp_coord_out_0,
   output logic [15:0] rsp_coord_out_1,
   output logic [15:0] rsp_coord_out_2,
   output logic [15:0] rsp_coord_out_3,
   output logic [1:0]  rsp_status
);
   import tirv_pkg::*;

   // Shape registers. The user must change them only while the pipeline is empty
   // (the block does not enforce this), so the first stage may read them directly.
   logic [2:0]                         num_dims_ff;
   logic [NUM_FIELDS-1:0][COORD_W-1:0] dim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff <= 3'd1;
         for (int i = 0; i < NUM_FIELDS; i++) dim_ff[i] <= 16'd1;
      end else if (csr_we) begin
         case (csr_index)
            REG_NUM_DIMS: num_dims_ff <= csr_wdata[2:0];
            REG_DIM_0:    dim_ff[0]   <= csr_wdata;
            REG_DIM_1:    dim_ff[1]   <= csr_wdata;
            REG_DIM_2:    dim_ff[2]   <= csr_wdata;
            REG_DIM_3:    dim_ff[3]   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The dimension count in use: zero counts as one, and anything past the
   // supported count is clipped.
   logic [2:0] used_n;
   always_comb begin
      used_n = num_dims_ff;
      if (used_n == 3'd0) used_n = 3'd1;
      if (used_n > 3'(MAX_DIMS)) used_n = 3'(MAX_DIMS);
      if (used_n > 3'(NUM_FIELDS)) used_n = 3'(NUM_FIELDS);
   end

   // Pipeline: each stage holds a word while its successor is full and
   // stalled, and loads as soon as it is empty or moving, so bubbles close up.
   tirv_stage_type                stg_ff [NUM_STAGES];
   tirv_stage_type                stg_in [NUM_STAGES];
   logic [NUM_STAGES-1:0]         vld_ff;
   logic [NUM_STAGES-1:0]         adv;

   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_adv
      if (k == NUM_STAGES - 1) begin : g_last
         assign adv[k] = !vld_ff[k] || rsp_ready;
      end else begin : g_mid
         assign adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (adv[k]) vld_ff[k] <= (k == 0) ? req_valid : vld_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (adv[k]) stg_ff[k] <= stg_in[k];
      end
   end

   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
      if (k == 0) begin : g_capture
         // Capture the request. Unused dimensions get extent 1 and coordinate
         // 0, so they drop out of strides, products and the range check.
         always_comb begin
            logic [NUM_FIELDS-1:0][COORD_W-1:0] cin;
            stg_in[k] = '0;
            cin = {req_coord_in_3, req_coord_in_2, req_coord_in_1, req_coord_in_0};
            stg_in[k].op  = req_type;
            stg_in[k].rem = req_flat_index_in;
            for (int i = 0; i < NUM_FIELDS; i++) begin
               if (3'(i) < used_n) begin
                  stg_in[k].ext[i] = dim_ff[i];
                  stg_in[k].crd[i] = cin[i];
                  if (cin[i] >= dim_ff[i]) stg_in[k].rng_bad = 1'b1;
               end else begin
                  stg_in[k].ext[i] = 16'd1;
               end
            end
         end
      end else if (k == 1) begin : g_pair
         // Pairwise products: outer pair for the volume, inner pair for strides.
         always_comb begin
            stg_in[k]    = stg_ff[k-1];
            stg_in[k].pa = STRIDE_W'(stg_ff[k-1].ext[0]) * STRIDE_W'(stg_ff[k-1].ext[1]);
            stg_in[k].pb = STRIDE_W'(stg_ff[k-1].ext[2]) * STRIDE_W'(stg_ff[k-1].ext[3]);
         end
      end else if (k == 2) begin : g_third
         always_comb begin
            logic [PROD_W-1:0] p3;
            stg_in[k] = stg_ff[k-1];
            p3 = PROD_W'(stg_ff[k-1].pa) * PROD_W'(stg_ff[k-1].ext[2]);
            stg_in[k].strd[3] = STRIDE_W'(1);
            stg_in[k].strd[2] = STRIDE_W'(stg_ff[k-1].ext[3]);
            stg_in[k].strd[1] = tirv_sat(PROD_W'(stg_ff[k-1].pb));
            // The overflow flag is sticky: a later zero extent does not clear it.
            stg_in[k].ovf = (PROD_W'(stg_ff[k-1].pa) > VOL_LIMIT) || (p3 > VOL_LIMIT);
            stg_in[k].pa  = tirv_sat(p3);
         end
      end else if (k == 3) begin : g_volume
         always_comb begin
            logic [PROD_W-1:0] s0, vol;
            logic              ovf;
            stg_in[k] = stg_ff[k-1];
            s0  = PROD_W'(stg_ff[k-1].ext[1]) * PROD_W'(stg_ff[k-1].strd[1]);
            vol = PROD_W'(stg_ff[k-1].pa) * PROD_W'(stg_ff[k-1].ext[3]);
            ovf = stg_ff[k-1].ovf || (vol > VOL_LIMIT);
            stg_in[k].strd[0] = tirv_sat(s0);
            stg_in[k].pa      = tirv_sat(vol);
            stg_in[k].ovf     = ovf;
            // Ravel checks range before overflow; unravel the other way round.
            if (stg_ff[k-1].op == OP_RAVEL) begin
               stg_in[k].sts = stg_ff[k-1].rng_bad ? STS_RANGE : (ovf ? STS_OVF : STS_OK);
            end else if (ovf) begin
               stg_in[k].sts = STS_OVF;
            end else if (STRIDE_W'(stg_ff[k-1].rem) >= tirv_sat(vol)) begin
               stg_in[k].sts = STS_RANGE;
            end else begin
               stg_in[k].sts = STS_OK;
            end
         end
      end else if (k < NUM_STAGES - 1) begin : g_divide
         // Restoring division by each stride in turn, outermost dimension
         // first, one quotient bit per step. Ravel products and their sum
         // ride along in the first two divider stages.
         always_comb begin
            logic [SHIFT_W-1:0] dvs, rw;
            int                 t;
            logic [1:0]         di;
            logic [3:0]         bp;
            stg_in[k] = stg_ff[k-1];
            if (k == DIV_FIRST) begin
               stg_in[k].qt = '0;
               for (int i = 0; i < NUM_FIELDS; i++) begin
                  stg_in[k].prod[i] = FLAT_W'(PROD_W'(stg_ff[k-1].crd[i]) *
                                              PROD_W'(stg_ff[k-1].strd[i]));
               end
            end
            if (k == DIV_FIRST + 1) begin
               stg_in[k].flat_sum = stg_ff[k-1].prod[0] + stg_ff[k-1].prod[1] +
                                    stg_ff[k-1].prod[2] + stg_ff[k-1].prod[3];
            end
            for (int j = 0; j < DIV_STEPS; j++) begin
               t   = (k - DIV_FIRST) * DIV_STEPS + j;
               di  = 2'(t / COORD_W);
               bp  = 4'(COORD_W - 1 - (t % COORD_W));
               dvs = SHIFT_W'(stg_in[k].strd[di]) << bp;
               rw  = SHIFT_W'(stg_in[k].rem);
               if (rw >= dvs) begin
                  stg_in[k].rem        = FLAT_W'(rw - dvs);
                  stg_in[k].qt[di][bp] = 1'b1;
               end
            end
         end
      end else begin : g_result
         // Only the result of a successful request survives; the rest is zero.
         always_comb begin
            stg_in[k] = stg_ff[k-1];
            if (!(stg_ff[k-1].op == OP_RAVEL && stg_ff[k-1].sts == STS_OK))
               stg_in[k].flat_sum = '0;
            if (!(stg_ff[k-1].op == OP_UNRAVEL && stg_ff[k-1].sts == STS_OK))
               stg_in[k].qt = '0;
         end
      end
   end

   assign rsp_valid          = vld_ff[NUM_STAGES-1];
   assign rsp_flat_index_out = stg_ff[NUM_STAGES-1].flat_sum;
   assign rsp_coord_out_0    = stg_ff[NUM_STAGES-1].qt[0];
   assign rsp_coord_out_1    = stg_ff[NUM_STAGES-1].qt[1];
   assign rsp_coord_out_2    = stg_ff[NUM_STAGES-1].qt[2];
   assign rsp_coord_out_3    = stg_ff[NUM_STAGES-1].qt[3];
   assign rsp_status         = stg_ff[NUM_STAGES-1].sts;

endmodule

// File: dv/tensor_index_ravel_unravel_core_tb.sv
// Testbench for tensor_index_ravel_unravel_core: random and directed ravel and
// unravel words checked against an in-bench shape model. Depends on tirv_pkg.
`timescale 1ns / 1ps
module tensor_index_ravel_unravel_core_tb;
   import tirv_pkg::*;

   // Expected response word.
   typedef struct {
      logic [30:0] flat;
      logic [15:0] crd [4];
      logic [1:0]  sts;
   } conv_word_type;

   // Shape model plus the queue of responses still owed by the block.
   class conv_scoreboard;
      logic [2:0]    num_dims;
      logic [15:0]   extent [4];
      conv_word_type pending [$];
      int            errors;

      function new();
         num_dims = 3'd1;
         foreach (extent[i]) extent[i] = 16'd1;
         errors = 0;
      endfunction

      // One line per mismatch; the count decides the final verdict.
      task report_mismatch(string msg);
         errors++;
         $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      function void write_reg(logic [2:0] idx, logic [15:0] val);
         if (idx == REG_NUM_DIMS) begin
            num_dims = val[2:0];
         end else if (idx <= REG_DIM_3) begin
            extent[idx - 1] = val;
         end
      endfunction

      // Works out the response to one accepted request word.
      function void note_request(logic op, logic [15:0] cin [4], logic [30:0] fin);
         conv_word_type w;
         int unsigned n;
         longint unsigned vol, v, rem;
         longint unsigned stride [4];
         bit ovf, bad;
         n = (num_dims == 0) ? 1 : ((num_dims > MAX_DIMS) ? MAX_DIMS : num_dims);
         w.flat = '0;
         w.sts = STS_OK;
         foreach (w.crd[i]) w.crd[i] = '0;
         // Volume from the outermost dimension inward; overflow sticks.
         vol = 1;
         ovf = 0;
         for (int i = 0; i < n; i++) begin
            vol = vol * extent[i];
            if (vol > 64'h7FFF_FFFF) ovf = 1;
            if (ovf) vol = 64'h8000_0000;
         end
         v = 1;
         for (int k = n - 1; k >= 0; k--) begin
            stride[k] = v;
            v = v * extent[k];
            if (v > 64'h7FFF_FFFF) v = 64'h8000_0000;
         end
         if (op == OP_RAVEL) begin
            bad = 0;
            for (int i = 0; i < n; i++) if (cin[i] >= extent[i]) bad = 1;
            if (bad) begin
               w.sts = STS_RANGE;
            end else if (ovf) begin
               w.sts = STS_OVF;
            end else begin
               v = 0;
               for (int i = 0; i < n; i++) v += cin[i] * stride[i];
               w.flat = v[30:0];
            end
         end else begin
            rem = fin;
            if (ovf) begin
               w.sts = STS_OVF;
            end else if (rem >= vol) begin
               w.sts = STS_RANGE;
            end else begin
               for (int i = 0; i < n; i++) begin
                  if (stride[i] != 0) begin
                     w.crd[i] = 16'(rem / stride[i]);
                     rem = rem % stride[i];
                  end
               end
            end
         end
         pending.insert(pending.size(), w);
      endfunction

      task check_response(logic [30:0] flat, logic [15:0] crd [4], logic [1:0] sts);
         conv_word_type w;
         if (pending.size() == 0) begin
            report_mismatch("response word with none expected");
            return;
         end
         w = pending.pop_front();
         if (flat !== w.flat)
            report_mismatch($sformatf("flat %0d, expected %0d", flat, w.flat));
         for (int i = 0; i < 4; i++)
            if (crd[i] !== w.crd[i])
               report_mismatch($sformatf("coord %0d is %0d, expected %0d", i,
                                         crd[i], w.crd[i]));
         if (sts !== w.sts)
            report_mismatch($sformatf("status %0d, expected %0d", sts, w.sts));
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_type = 0;
   logic [15:0] req_coord_in_0 = '0, req_coord_in_1 = '0;
   logic [15:0] req_coord_in_2 = '0, req_coord_in_3 = '0;
   logic [30:0] req_flat_index_in = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [30:0] rsp_flat_index_out;
   logic [15:0] rsp_coord_out_0, rsp_coord_out_1, rsp_coord_out_2, rsp_coord_out_3;
   logic [1:0]  rsp_status;

   conv_scoreboard board = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles = 0;
   localparam int WATCHDOG_LIMIT = 20000;

   always #2 clock = ~clock;

   tensor_index_ravel_unravel_core DUT (.*);

   // Both handshakes are sampled at the rising edge, where the model is updated.
   always @(posedge clock) begin
      logic [15:0] cin [4];
      logic [15:0] cout [4];
      if (!reset) begin
         if (req_valid && req_ready) begin
            cin = '{req_coord_in_0, req_coord_in_1, req_coord_in_2, req_coord_in_3};
            board.note_request(req_type, cin, req_flat_index_in);
         end
         if (rsp_valid && rsp_ready) begin
            cout = '{rsp_coord_out_0, rsp_coord_out_1, rsp_coord_out_2,
                     rsp_coord_out_3};
            board.check_response(rsp_flat_index_out, cout, rsp_status);
         end
         // The watchdog only runs while work is owed or offered.
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)
             || (!req_valid && board.pending.size() == 0))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // The receiver stalls at random, decided on each falling edge.
   always @(negedge clock)
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);

   task automatic write_csr(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      board.write_reg(idx, val);
   endtask

   // Withdraws the request, waits for every owed word, then for the depth.
   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (45) @(negedge clock);
   endtask

   task automatic set_shape(logic [2:0] nd, logic [15:0] e0, logic [15:0] e1,
                            logic [15:0] e2, logic [15:0] e3);
      drain();
      write_csr(REG_NUM_DIMS, {13'd0, nd});
      write_csr(REG_DIM_0, e0);
      write_csr(REG_DIM_1, e1);
      write_csr(REG_DIM_2, e2);
      write_csr(REG_DIM_3, e3);
   endtask

   // Presents one request word at a falling edge and holds it until taken.
   // Valid is left to the next word, an idle cycle or the drain.
   task automatic send_word(logic op, logic [15:0] c0, logic [15:0] c1,
                            logic [15:0] c2, logic [15:0] c3, logic [30:0] fi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid         <= 1;
      req_type          <= op;
      req_coord_in_0    <= c0;
      req_coord_in_1    <= c1;
      req_coord_in_2    <= c2;
      req_coord_in_3    <= c3;
      req_flat_index_in <= fi;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_coord(logic [15:0] ext);
      case ($urandom_range(5))
         0: return 16'($urandom);
         1: return ext;
         2: return (ext == 0) ? 16'd0 : ext - 1;
         default: return (ext == 0) ? 16'd0 : 16'($urandom_range(ext - 1));
      endcase
   endfunction

   // A word that is mostly well formed for the present shape.
   task automatic send_random();
      logic [15:0] c [4];
      longint unsigned vol;
      logic [30:0] fi;
      vol = 1;
      for (int i = 0; i < 4; i++) begin
         c[i] = pick_coord(board.extent[i]);
         if (i < board.num_dims) vol = vol * board.extent[i];
      end
      case ($urandom_range(4))
         0: fi = 31'($urandom);
         1: fi = (vol > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : 31'(vol);
         default: fi = (vol == 0) ? 31'd0
                       : 31'($urandom % ((vol > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : vol));
      endcase
      send_word(1'($urandom), c[0], c[1], c[2], c[3], fi);
   endtask

   task automatic random_shape();
      logic [15:0] e [4];
      for (int i = 0; i < 4; i++)
         case ($urandom_range(5))
            0: e[i] = 16'($urandom);
            1: e[i] = 16'd0;
            2: e[i] = 16'hFFFF;
            default: e[i] = 16'($urandom_range(1, 40));
         endcase
      set_shape(3'($urandom), e[0], e[1], e[2], e[3]);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Reset shape: one dimension of extent 1.
      send_word(OP_RAVEL, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
      send_word(OP_UNRAVEL, 0, 0, 0, 0, 0);
      send_word(OP_UNRAVEL, 0, 0, 0, 0, 31'h7FFF_FFFF);
      // Four dimensions, small shape 3x4x5x6.
      set_shape(3'd4, 16'd3, 16'd4, 16'd5, 16'd6);
      send_word(OP_RAVEL, 2, 3, 4, 5, 0);
      send_word(OP_RAVEL, 3, 0, 0, 0, 0);
      send_word(OP_UNRAVEL, 0, 0, 0, 0, 31'd359);
      send_word(OP_UNRAVEL, 0, 0, 0, 0, 31'd360);
      // Overflow that a later zero extent cannot undo, and both orderings.
      set_shape(3'd4, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1);
      send_word(OP_RAVEL, 0, 0, 0, 0, 0);
      send_word(OP_UNRAVEL, 0, 0, 0, 0, 0);
      set_shape(3'd2, 16'hFFFF, 16'hFFFF, 16'd7, 16'd7);
      send_word(OP_RAVEL, 1, 1, 0, 0, 0);
      // Zero extent without overflow.
      set_shape(3'd3, 16'd5, 16'd0, 16'd5, 16'd5);
      send_word(OP_RAVEL, 0, 0, 0, 0, 0);
      send_word(OP_UNRAVEL, 0, 0, 0, 0, 0);
      // Dimension count zero and above the limit.
      set_shape(3'd0, 16'd10, 16'd2, 16'd2, 16'd2);
      send_word(OP_RAVEL, 9, 16'hFFFF, 0, 0, 0);
      send_word(OP_UNRAVEL, 0, 0, 0, 0, 31'd9);
      set_shape(3'd7, 16'd2, 16'd3, 16'd4, 16'd5);
      send_word(OP_RAVEL, 1, 2, 3, 4, 0);
      send_word(OP_UNRAVEL, 0, 0, 0, 0, 31'd119);
      // Volume just below the limit: 32768*65535 fits.
      set_shape(3'd2, 16'd32768, 16'hFFFF, 16'd1, 16'd1);
      send_word(OP_RAVEL, 16'd32767, 16'hFFFE, 0, 0, 0);
      send_word(OP_UNRAVEL, 0, 0, 0, 0, 31'h7FFE_FFFF);
      // Register index beyond the last register is ignored.
      drain();
      write_csr(3'd5, 16'd0);
      write_csr(3'd7, 16'd0);
      send_word(OP_RAVEL, 1, 2, 3, 4, 0);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 75 : 0;
         recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 29 : 0;
         for (int blk = 0; blk < 12; blk++) begin
            random_shape();
            repeat (48) send_random();
         end
      end

      send_idle_pct = 0;
      drain();
      if (board.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
